// ===== rtl/core/rfbt_pkg.sv =====
// Shared types, widths, register indexes and the quarter-wave cosine table.
package rfbt_pkg;

    localparam int POS_W         = 24;
    localparam int FIT_W         = 40;
    localparam int PIDX_W        = 10;
    localparam int DIMS_W        = 7;
    localparam int SWARM_W       = 11;
    localparam int CNT_W         = 6;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int MAX_PARTICLES = 1024;
    localparam int MAX_DIMS      = 64;
    localparam int QDEPTH        = 8;
    localparam int QPTR_W        = 3;
    localparam int WAVE_W        = 20;
    localparam int OUT_W         = 144;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIMS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWARM = 2'd1;

    // One completed particle on its way from the front to the back.
    typedef struct packed {
        logic [PIDX_W-1:0] particle;
        logic [FIT_W-1:0]  fit;
        logic              first;
        logic              done;
        logic              pass_start;
    } t_job;

    // round(655360 * cos(k*pi/32)) for k = 0..16; beyond the quarter it is zero.
    function automatic logic [WAVE_W-1:0] qwave(input logic [4:0] k);
        logic [WAVE_W-1:0] v;
        case (k)
            5'd0:    v = 20'd655360;
            5'd1:    v = 20'd652204;
            5'd2:    v = 20'd642767;
            5'd3:    v = 20'd627140;
            5'd4:    v = 20'd605474;
            5'd5:    v = 20'd577976;
            5'd6:    v = 20'd544912;
            5'd7:    v = 20'd506600;
            5'd8:    v = 20'd463410;
            5'd9:    v = 20'd415756;
            5'd10:   v = 20'd364099;
            5'd11:   v = 20'd308935;
            5'd12:   v = 20'd250795;
            5'd13:   v = 20'd190241;
            5'd14:   v = 20'd127854;
            5'd15:   v = 20'd64237;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rfbt_front.sv =====
// Front: per-coordinate Rastrigin term pipeline, accumulation and particle counting.
module rfbt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [rfbt_pkg::POS_W-1:0]          i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic [rfbt_pkg::DIMS_W-1:0]         i_dims_eff,
    input  logic [rfbt_pkg::SWARM_W-1:0]        i_swarm_eff,
    input  logic [rfbt_pkg::QPTR_W:0]           i_q_count,
    output logic                                o_push,
    output rfbt_pkg::t_job                      o_job
);

    logic accept;

    // Stage 1: magnitude, quadrant fold and table read.
    logic                              r1_valid;
    logic [rfbt_pkg::POS_W-1:0]        r1_mag;
    logic [rfbt_pkg::WAVE_W-1:0]       r1_ti;
    logic [rfbt_pkg::WAVE_W-1:0]       r1_diff;
    logic [9:0]                        r1_t;
    logic                              r1_neg;
    logic                              r1_first;

    // Stage 2: products.
    logic                              r2_valid;
    logic [2*rfbt_pkg::POS_W-1:0]      r2_sq;
    logic [rfbt_pkg::WAVE_W+9:0]       r2_prod;
    logic [rfbt_pkg::WAVE_W-1:0]       r2_ti;
    logic                              r2_neg;
    logic                              r2_first;

    // Stage 3: finished term.
    logic                              r3_valid;
    logic [31:0]                       r3_term;
    logic                              r3_first;

    logic [rfbt_pkg::FIT_W-1:0]        r_term_sum;
    logic [rfbt_pkg::CNT_W-1:0]        r_coord_count;
    logic [rfbt_pkg::PIDX_W-1:0]       r_particle_count;

    logic [rfbt_pkg::POS_W-1:0]        mag;
    logic [1:0]                        quad;
    logic [14:0]                       u;
    logic [4:0]                        k;
    logic [rfbt_pkg::WAVE_W-1:0]       t_lo;
    logic [rfbt_pkg::WAVE_W-1:0]       t_hi;
    logic [rfbt_pkg::WAVE_W+10:0]      prod_rnd;
    logic [rfbt_pkg::WAVE_W-1:0]       quarter;
    logic [2*rfbt_pkg::POS_W:0]        sq_rnd;
    logic [31:0]                       sq_q;
    logic [31:0]                       term;
    logic [rfbt_pkg::FIT_W-1:0]        sum_next;
    logic                              last_coord;
    logic                              pass_end;
    logic [rfbt_pkg::QPTR_W+1:0]       reserved;

    // Room is kept in the queue for every coordinate still in the pipeline.
    assign reserved   = {1'b0, i_q_count} + {4'd0, r1_valid} + {4'd0, r2_valid}
                      + {4'd0, r3_valid};
    assign o_s_tready = (reserved < (rfbt_pkg::QPTR_W+2)'(rfbt_pkg::QDEPTH));
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        mag  = i_s_tdata[rfbt_pkg::POS_W-1] ? (~i_s_tdata + 24'd1) : i_s_tdata;
        quad = i_s_tdata[15:14];
        u    = quad[0] ? (15'd16384 - {1'b0, i_s_tdata[13:0]}) : {1'b0, i_s_tdata[13:0]};
        k    = u[14:10];
        t_lo = rfbt_pkg::qwave(k);
        t_hi = rfbt_pkg::qwave(k + 5'd1);
    end

    always_comb begin
        prod_rnd = {1'b0, r2_prod} + 31'd512;
        quarter  = r2_ti - prod_rnd[rfbt_pkg::WAVE_W+9:10];
        sq_rnd   = {1'b0, r2_sq} + 49'd32768;
        sq_q     = sq_rnd[47:16];
        if (r2_neg) begin
            term = sq_q + 32'd655360 + {12'd0, quarter};
        end else begin
            term = sq_q + 32'd655360 - {12'd0, quarter};
        end
    end

    always_comb begin
        sum_next   = r_term_sum + {8'd0, r3_term};
        last_coord = ({1'b0, r_coord_count} + 7'd1) >= i_dims_eff;
        pass_end   = ({1'b0, r_particle_count} + 11'd1) >= i_swarm_eff;
    end

    assign o_push          = r3_valid && last_coord;
    assign o_job.particle   = r_particle_count;
    assign o_job.fit        = sum_next;
    assign o_job.first      = r3_first;
    assign o_job.done       = pass_end;
    assign o_job.pass_start = (r_particle_count == '0);

    always_ff @(posedge i_clk) begin
        r1_mag   <= mag;
        r1_ti    <= t_lo;
        r1_diff  <= t_lo - t_hi;
        r1_t     <= u[9:0];
        r1_neg   <= (quad == 2'd1) || (quad == 2'd2);
        r1_first <= i_s_tuser;

        r2_sq    <= r1_mag * r1_mag;
        r2_prod  <= r1_diff * r1_t;
        r2_ti    <= r1_ti;
        r2_neg   <= r1_neg;
        r2_first <= r1_first;

        r3_term  <= term;
        r3_first <= r2_first;

        if (!i_rst_n) begin
            r1_valid         <= 1'b0;
            r2_valid         <= 1'b0;
            r3_valid         <= 1'b0;
            r_term_sum       <= '0;
            r_coord_count    <= '0;
            r_particle_count <= '0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            if (r3_valid) begin
                if (last_coord) begin
                    r_term_sum    <= '0;
                    r_coord_count <= '0;
                    if (pass_end) begin
                        r_particle_count <= '0;
                    end else begin
                        r_particle_count <= r_particle_count + 10'd1;
                    end
                end else begin
                    r_term_sum    <= sum_next;
                    r_coord_count <= r_coord_count + 6'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/rfbt_queue.sv =====
// Short queue of completed particles between the front and the back.
module rfbt_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  rfbt_pkg::t_job             i_job,
    input  logic                       i_pop,
    output logic                       o_valid,
    output rfbt_pkg::t_job             o_job,
    output logic [rfbt_pkg::QPTR_W:0]  o_count
);

    rfbt_pkg::t_job                 r_slot [rfbt_pkg::QDEPTH];
    logic [rfbt_pkg::QPTR_W-1:0]    r_wr;
    logic [rfbt_pkg::QPTR_W-1:0]    r_rd;
    logic [rfbt_pkg::QPTR_W:0]      r_count;

    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 3'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 3'd1;
            end
            r_count <= r_count + {3'd0, i_push} - {3'd0, i_pop};
        end
    end

endmodule

// ===== rtl/core/rfbt_back.sv =====
// Back: personal best store, pass minimum, global best and the output register.
module rfbt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  rfbt_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rfbt_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast
);

    logic [rfbt_pkg::FIT_W-1:0]   r_best [rfbt_pkg::MAX_PARTICLES];

    logic                         r_s1_valid;
    rfbt_pkg::t_job               r_s1_job;
    logic [rfbt_pkg::FIT_W-1:0]   r_rd_data;
    logic                         r_fwd;
    logic [rfbt_pkg::FIT_W-1:0]   r_fwd_data;

    logic [rfbt_pkg::FIT_W-1:0]   r_pmin_val;
    logic [rfbt_pkg::PIDX_W-1:0]  r_pmin_idx;
    logic [rfbt_pkg::FIT_W-1:0]   r_gbest_val;
    logic [rfbt_pkg::PIDX_W-1:0]  r_gbest_idx;

    logic                         r_out_valid;
    logic [rfbt_pkg::OUT_W-1:0]   r_out_data;
    logic                         r_out_last;

    logic                         commit;
    logic                         wr_en;
    logic [rfbt_pkg::FIT_W-1:0]   old_best;
    logic                         pimp;
    logic [rfbt_pkg::FIT_W-1:0]   pb;
    logic                         take_min;
    logic [rfbt_pkg::FIT_W-1:0]   n_pmin_val;
    logic [rfbt_pkg::PIDX_W-1:0]  n_pmin_idx;
    logic                         gimp;
    logic [rfbt_pkg::FIT_W-1:0]   n_gbest_val;
    logic [rfbt_pkg::PIDX_W-1:0]  n_gbest_idx;
    logic                         fit_lt_pmin;
    logic                         old_lt_pmin;
    logic                         fit_lt_g;
    logic                         old_lt_g;
    logic                         pmin_lt_g;
    logic                         pb_lt_g;
    logic [rfbt_pkg::FIT_W-1:0]   out_gval;
    logic [rfbt_pkg::PIDX_W-1:0]  out_gidx;

    assign commit = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_pop  = i_q_valid && (!r_s1_valid || commit);

    always_comb begin
        old_best    = r_fwd ? r_fwd_data : r_rd_data;
        pimp        = r_s1_job.first || (r_s1_job.fit < old_best);
        pb          = pimp ? r_s1_job.fit : old_best;
        // All compares run side by side; the selections follow.
        fit_lt_pmin = r_s1_job.fit < r_pmin_val;
        old_lt_pmin = old_best < r_pmin_val;
        fit_lt_g    = r_s1_job.fit < r_gbest_val;
        old_lt_g    = old_best < r_gbest_val;
        pmin_lt_g   = r_pmin_val < r_gbest_val;
        pb_lt_g     = pimp ? fit_lt_g : old_lt_g;
        take_min    = r_s1_job.pass_start || (pimp ? fit_lt_pmin : old_lt_pmin);
        n_pmin_val  = take_min ? pb : r_pmin_val;
        n_pmin_idx  = take_min ? r_s1_job.particle : r_pmin_idx;
        gimp        = r_s1_job.done && (r_s1_job.first || (take_min ? pb_lt_g : pmin_lt_g));
        n_gbest_val = gimp ? n_pmin_val : r_gbest_val;
        n_gbest_idx = gimp ? n_pmin_idx : r_gbest_idx;
        out_gval    = r_s1_job.done ? n_gbest_val : '0;
        out_gidx    = r_s1_job.done ? n_gbest_idx : '0;
        wr_en       = commit && pimp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_best[r_s1_job.particle] <= r_s1_job.fit;
        end
        if (o_pop) begin
            r_rd_data <= r_best[i_job.particle];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_job   <= i_job;
            r_fwd_data <= r_s1_job.fit;
        end
        if (commit) begin
            r_out_data <= {2'b00, gimp, out_gidx, out_gval, pimp, pb,
                           r_s1_job.fit, r_s1_job.particle};
            r_out_last <= r_s1_job.done;
        end
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pmin_val  <= '1;
            r_pmin_idx  <= '0;
            r_gbest_val <= '1;
            r_gbest_idx <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
                // A write to the same entry in this cycle is missed by the read.
                r_fwd      <= wr_en && (i_job.particle == r_s1_job.particle);
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_pmin_val  <= n_pmin_val;
                r_pmin_idx  <= n_pmin_idx;
                r_gbest_val <= n_gbest_val;
                r_gbest_idx <= n_gbest_idx;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/core/rastrigin_fitness_best_tracker.sv =====
// Top level of the Rastrigin fitness evaluator with personal and global best tracking.
// Throughput: one coordinate transfer per cycle while the queue has room, and at most
// one result per cycle. A result follows the transfer of the coordinate that completes
// its particle via three term stages, queue, best-store read and output register.
// Reset is synchronous and active low; it clears counters, sums and the queue, sets bests
// to all ones, dims to 10 and swarm_size to 1024. The personal best store is not cleared.
module rastrigin_fitness_best_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Coordinate stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [rfbt_pkg::POS_W-1:0]           i_s_tdata,  // [23:0] position
    input  logic                                 i_s_tuser,  // [0] first_pass
    // Result stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [9:0] particle, [49:10] fitness, [89:50] personal_best, [90] personal_improved,
    // [130:91] global_best, [140:131] global_best_particle, [141] global_improved,
    // [143:142] zero
    output logic [rfbt_pkg::OUT_W-1:0]           o_m_tdata,
    output logic                                 o_m_tlast,  // pass_done
    // Configuration writes.
    input  logic                                 i_cfg_we,
    input  logic [rfbt_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rfbt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    // The configuration registers hold what was written; the values used are
    // clamped to the supported ranges, so that zero behaves as one and any
    // larger count behaves as the maximum.
    logic [rfbt_pkg::DIMS_W-1:0]   r_dims;
    logic [rfbt_pkg::SWARM_W-1:0]  r_swarm;
    logic [rfbt_pkg::DIMS_W-1:0]   dims_eff;
    logic [rfbt_pkg::SWARM_W-1:0]  swarm_eff;

    logic                          push;
    rfbt_pkg::t_job                push_job;
    logic                          pop;
    logic                          q_valid;
    rfbt_pkg::t_job                q_job;
    logic [rfbt_pkg::QPTR_W:0]     q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= 7'd10;
            r_swarm <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rfbt_pkg::CFG_DIMS:  r_dims  <= i_cfg_wdata[rfbt_pkg::DIMS_W-1:0];
                rfbt_pkg::CFG_SWARM: r_swarm <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_dims == '0) begin
            dims_eff = 7'd1;
        end else if (r_dims > 7'(rfbt_pkg::MAX_DIMS)) begin
            dims_eff = 7'(rfbt_pkg::MAX_DIMS);
        end else begin
            dims_eff = r_dims;
        end
        if (r_swarm == '0) begin
            swarm_eff = 11'd1;
        end else if (r_swarm > 11'(rfbt_pkg::MAX_PARTICLES)) begin
            swarm_eff = 11'(rfbt_pkg::MAX_PARTICLES);
        end else begin
            swarm_eff = r_swarm;
        end
    end

    // The front takes a coordinate in every cycle in which the queue has room
    // for everything already in flight, so it never has to stall mid-pipeline.
    rfbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_dims_eff  (dims_eff),
        .i_swarm_eff (swarm_eff),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_job       (push_job)
    );

    rfbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // The back registers the particle's personal best as it pops the particle, ahead
    // of the update; back-to-back updates of the same particle are forwarded. The
    // output register lets the back take in the next particle while the previous
    // result waits for its transfer.
    rfbt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Rastrigin fitness evaluator with best tracking.
`timescale 1ns / 1ps

module tb_top;

    import rfbt_pkg::*;

    // The spare register index decodes to nothing; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd2;

    // Margin beyond the pipeline depth from the completing coordinate.
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 200;
    localparam int TIMEOUT_NS    = 4_000_000;

    // Quarter-wave cosine samples, 10*cos(k*pi/32) in Q.16, k = 0..16.
    localparam int COS_WAVE [17] = '{
        655360, 652204, 642767, 627140, 605474, 577976, 544912, 506600,
        463410, 415756, 364099, 308935, 250795, 190241, 127854, 64237, 0
    };

    // Random phases: register settings and the number of coordinates in each.
    localparam int PHASES = 6;
    localparam int PHASE_DIMS  [PHASES] = '{1, 3, 64, 2, 1, 5};
    localparam int PHASE_SWARM [PHASES] = '{3, 5, 2, 1, 1024, 6};
    localparam int PHASE_ITEMS [PHASES] = '{120, 150, 130, 60, 400, 100};

    typedef enum logic {
        ROW_WRITE,
        ROW_COORD
    } row_kind_e;

    // One line of the directed part: either a register write or a coordinate.
    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [POS_W-1:0]       pos;
        logic                   first_pass;
        logic                   typed;
        logic [FIT_W-1:0]       fit_typed;
    } stim_row_t;

    // Everything one completed particle reports on the result stream.
    typedef struct packed {
        logic [PIDX_W-1:0] particle;
        logic [FIT_W-1:0]  fitness;
        logic [FIT_W-1:0]  personal_best;
        logic              personal_improved;
        logic              pass_done;
        logic [FIT_W-1:0]  global_best;
        logic [PIDX_W-1:0] global_best_particle;
        logic              global_improved;
    } fitness_result_t;

    // Directed part. With dims at one every coordinate is a whole particle, so the
    // fitness of most rows is the term of that single coordinate and is typed in.
    localparam int DIR_ROWS = 26;
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_WRITE, CFG_DIMS,  11'd1,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_WRITE, CFG_SWARM, 11'd3,    24'h000000, 1'b0, 1'b0, 40'd0},
        // First pass: zero, the most negative and the most positive coordinate.
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000000, 1'b1, 1'b1, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h800000, 1'b1, 1'b1, 40'd1073741824},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h7FFFFF, 1'b1, 1'b1, 40'd1073741571},
        // Second pass: a worse value, then improvements, one tying the pass minimum.
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h008000, 1'b0, 1'b1, 40'd1327104},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000000, 1'b0, 1'b1, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h010000, 1'b0, 1'b1, 40'd65536},
        // Third pass: symmetric values and the smallest steps either side of zero.
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'hFF0000, 1'b0, 1'b1, 40'd65536},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000001, 1'b0, 1'b1, 40'd3},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'hFFFFFF, 1'b0, 1'b1, 40'd3},
        // Zero in both registers is clamped to one.
        '{ROW_WRITE, CFG_DIMS,  11'd0,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_WRITE, CFG_SWARM, 11'd0,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000000, 1'b1, 1'b1, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h004000, 1'b0, 1'b1, 40'd659456},
        // A write to the spare index changes nothing.
        '{ROW_WRITE, CFG_SPARE, 11'd5,    24'h000000, 1'b0, 1'b0, 40'd0},
        // Oversized settings are clamped to the maximum dims and swarm.
        '{ROW_WRITE, CFG_DIMS,  11'd127,  24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_WRITE, CFG_SWARM, 11'd2047, 24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h123456, 1'b1, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'hABCDEF, 1'b0, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000000, 1'b1, 1'b0, 40'd0},
        // Shrinking dims mid-particle: the next coordinate completes it.
        '{ROW_WRITE, CFG_DIMS,  11'd4,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h7FFFFF, 1'b0, 1'b0, 40'd0},
        // Shrinking the swarm mid-pass: the next particle ends the pass.
        '{ROW_WRITE, CFG_SWARM, 11'd1,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_WRITE, CFG_DIMS,  11'd1,    24'h000000, 1'b0, 1'b0, 40'd0},
        '{ROW_COORD, CFG_DIMS,  11'd0,    24'h000000, 1'b0, 1'b1, 40'd0}
    };

    // Block ports. Every input has a known value from time zero.
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [POS_W-1:0]      i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Idle rates of the two sides in percent, and long receiver hold-offs asked for.
    int src_idle_pct    = 10;
    int snk_idle_pct    = 82;
    int holds_requested = 0;

    // Shadow of the block's registers and state, kept in step with accepted transfers.
    logic [DIMS_W-1:0]  dims_reg      = 7'd10;
    logic [SWARM_W-1:0] swarm_reg     = 11'd1024;
    logic [FIT_W-1:0]   sum_acc       = '0;
    int                 coord_idx     = 0;
    int                 particle_idx  = 0;
    logic [FIT_W-1:0]   best_mem [MAX_PARTICLES];
    bit                 best_written [MAX_PARTICLES];
    logic [FIT_W-1:0]   pass_min_fit  = '1;
    logic [PIDX_W-1:0]  pass_min_idx  = '0;
    logic [FIT_W-1:0]   global_fit    = '1;
    logic [PIDX_W-1:0]  global_idx    = '0;

    fitness_result_t fitness_results_due [$];
    int              mismatch_count = 0;

    rastrigin_fitness_best_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial begin
        #(TIMEOUT_NS);
        $display("rastrigin_fitness_best_tracker test failed");
        $finish;
    end

    // Interpolated quarter wave at u = 0..16384; zero at the end of the quarter.
    function automatic longint quarter_wave(input int u);
        int     i;
        int     t;
        longint diff;
        i = u >> 10;
        t = u & 1023;
        if (i >= 16)
            return 0;
        diff = COS_WAVE[i] - COS_WAVE[i + 1];
        return COS_WAVE[i] - ((diff * t + 512) >> 10);
    endfunction

    // 10*cos(2*pi*x) in Q.16, built from the quadrant and offset of the fraction.
    function automatic longint cos_times_ten(input logic [15:0] phase);
        int r;
        r = int'(phase[13:0]);
        case (phase[15:14])
            2'd0:    return quarter_wave(r);
            2'd1:    return -quarter_wave(16384 - r);
            2'd2:    return -quarter_wave(r);
            default: return quarter_wave(16384 - r);
        endcase
    endfunction

    // One coordinate's contribution x*x + 10 - 10*cos(2*pi*x), never negative.
    function automatic logic [FIT_W-1:0] coordinate_term(input logic [POS_W-1:0] x);
        logic [POS_W-1:0] mag;
        longint           sq;
        mag = x[POS_W-1] ? (~x + 1'b1) : x;
        sq  = (longint'(mag) * longint'(mag) + 32768) >>> 16;
        return FIT_W'(sq + 655360 - cos_times_ten(x[15:0]));
    endfunction

    function automatic int eff_dims();
        if (dims_reg == 0)
            return 1;
        if (dims_reg > MAX_DIMS)
            return MAX_DIMS;
        return int'(dims_reg);
    endfunction

    function automatic int eff_swarm();
        if (swarm_reg == 0)
            return 1;
        if (swarm_reg > MAX_PARTICLES)
            return MAX_PARTICLES;
        return int'(swarm_reg);
    endfunction

    // Advances the shadow state by one coordinate. Returns 1 and fills res when the
    // coordinate completes a particle.
    function automatic bit predict_fitness(input logic [POS_W-1:0] pos, input logic fp,
                                           output fitness_result_t res);
        logic [FIT_W-1:0]  fit;
        logic [FIT_W-1:0]  pb;
        logic [PIDX_W-1:0] p;
        bit                done;
        res     = '0;
        sum_acc = sum_acc + coordinate_term(pos);
        if (coord_idx + 1 < eff_dims()) begin
            coord_idx++;
            return 1'b0;
        end
        coord_idx = 0;
        fit       = sum_acc;
        sum_acc   = '0;
        p         = PIDX_W'(particle_idx);

        // Personal best: written outright on a first pass, else only if strictly better.
        if (fp || fit < best_mem[p]) begin
            best_mem[p]           = fit;
            best_written[p]       = 1'b1;
            res.personal_improved = 1'b1;
        end
        pb = best_mem[p];

        // First minimum over the pass; a tie keeps the lower index.
        if (particle_idx == 0 || pb < pass_min_fit) begin
            pass_min_fit = pb;
            pass_min_idx = p;
        end

        done = (particle_idx + 1 >= eff_swarm());
        if (done) begin
            if (fp || pass_min_fit < global_fit) begin
                global_fit          = pass_min_fit;
                global_idx          = pass_min_idx;
                res.global_improved = 1'b1;
            end
            res.global_best          = global_fit;
            res.global_best_particle = global_idx;
            particle_idx             = 0;
        end else begin
            particle_idx++;
        end
        res.particle      = p;
        res.fitness       = fit;
        res.personal_best = pb;
        res.pass_done     = done;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    // Result checker. A transfer on the result stream is compared field by field with
    // the oldest expectation; outputs are sampled at the edge, before they change.
    always @(posedge i_clk) begin : result_check
        fitness_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (fitness_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer for particle %0d", o_m_tdata[9:0]);
            end else begin
                want = fitness_results_due.pop_front();
                check_field("particle",             want.particle,             o_m_tdata[9:0]);
                check_field("fitness",              want.fitness,              o_m_tdata[49:10]);
                check_field("personal_best",        want.personal_best,        o_m_tdata[89:50]);
                check_field("personal_improved",    want.personal_improved,    o_m_tdata[90]);
                check_field("pass_done",            want.pass_done,            o_m_tlast);
                check_field("global_best",          want.global_best,          o_m_tdata[130:91]);
                check_field("global_best_particle", want.global_best_particle,
                            o_m_tdata[140:131]);
                check_field("global_improved",      want.global_improved,      o_m_tdata[141]);
                check_field("padding",              0,                         o_m_tdata[143:142]);
            end
        end
    end

    // Receiver. Each cycle it takes or refuses a transfer at the current idle rate.
    // When the stimulus asks, it refuses for a long stretch so that the result queue
    // fills and back-pressure reaches the coordinate input.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != holds_requested) begin
                holds_served = holds_requested;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Offers one coordinate and waits for its transfer; the shadow state advances at
    // that edge. Afterwards each cycle is idle at the sender's idle rate. tvalid stays
    // high into the next call unless an idle cycle is drawn, so it is never lowered and
    // raised within one time step.
    task automatic deliver_coordinate(input logic [POS_W-1:0] pos, input logic fp,
                                      input logic typed, input logic [FIT_W-1:0] fit_typed);
        fitness_result_t res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pos;
        i_s_tuser  <= fp;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        if (predict_fitness(pos, fp, res)) begin
            if (typed)
                res.fitness = fit_typed;
            fitness_results_due.push_back(res);
        end
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge i_clk);
        end
    endtask

    // Sender pause: offers nothing until every expected result has been taken.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fitness_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Brings the block to rest before a register write. A partial particle produces
    // no result, so waiting SETTLE_CYCLES more lets its last coordinate clear the pipeline.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            CFG_DIMS:  dims_reg  = data[DIMS_W-1:0];
            CFG_SWARM: swarm_reg = data[SWARM_W-1:0];
            default:   ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Coordinates are weighted towards small magnitudes, where fitness is low enough
    // for bests to improve, with full-range values to exercise every bit.
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return POS_W'($urandom);
            4, 5, 6:    return POS_W'($urandom_range(0, 262143) - 131072);
            7:          return POS_W'((int'($urandom_range(0, 6)) - 3) * 65536);
            8:          return '0;
            default:    return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
        endcase
    endfunction

    initial begin : stimulus
        stim_row_t row;
        logic      completes;
        logic      fp;
        int        total_items;
        int        item_no;

        // Synchronous reset, held low from time zero and released once.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: register writes wait for the block to go quiet first.
        for (int k = 0; k < DIR_ROWS; k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_register(row.addr, row.wdata);
            end else begin
                deliver_coordinate(row.pos, row.first_pass, row.typed, row.fit_typed);
            end
        end

        total_items = 0;
        for (int ph = 0; ph < PHASES; ph++)
            total_items += PHASE_ITEMS[ph];

        // Random part. The idle pattern moves from a slow receiver, to a slow sender,
        // to no idling at all, by thirds of the random transfers.
        item_no = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_register(CFG_DIMS,  CFG_DATA_W'(PHASE_DIMS[ph]));
            write_register(CFG_SWARM, CFG_DATA_W'(PHASE_SWARM[ph]));
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                if (item_no < total_items / 3) begin
                    src_idle_pct = 10;
                    snk_idle_pct = 82;
                end else if (item_no < 2 * total_items / 3) begin
                    src_idle_pct = 82;
                    snk_idle_pct = 10;
                end else begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end

                // In the first phase every coordinate is a result: a long receiver
                // hold-off fills the block, and later the sender waits for it to empty.
                if (ph == 0 && n == 30)
                    holds_requested++;
                if (ph == 0 && n == 80)
                    drain_results();

                // A personal best that was never written must not be compared against,
                // so a particle without one is always completed as a first pass.
                completes = (coord_idx + 1 >= eff_dims());
                if (completes && !best_written[particle_idx])
                    fp = 1'b1;
                else
                    fp = ($urandom_range(0, 99) < 15);
                deliver_coordinate(pick_position(), fp, 1'b0, '0);
                item_no++;
            end
        end

        // Wind-down: wait for every expected result, then a little longer for strays.
        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (mismatch_count == 0 && fitness_results_due.size() == 0)
            $display("rastrigin_fitness_best_tracker test passed");
        else
            $display("rastrigin_fitness_best_tracker test failed");
        $finish;
    end

endmodule
